// ===== rtl/u8d_pkg.sv =====
// shared types, opcodes and lead offset table for the utf-8 decoder
`timescale 1ns / 1ps

package u8d_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned TRAIL_W = 3;
    localparam int unsigned OP_W    = 2;

    localparam logic [OP_W-1:0] OP_BYTE = 2'd0;
    localparam logic [OP_W-1:0] OP_PASS = 2'd1;
    localparam logic [OP_W-1:0] OP_END  = 2'd2;

    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_UTF8_DECODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_CODE    = 8'd1;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [TRAIL_W-1:0] trail;
        logic [WORD_W-1:0]  value;
    } t_op;

    typedef struct packed {
        logic              at_end;
        logic [WORD_W-1:0] value;
    } t_res;

    function automatic logic [TRAIL_W-1:0] trail_count_of(input logic [7:0] b);
        logic [TRAIL_W-1:0] n;
        if (b inside {[8'h00:8'hBF]}) n = 3'd0;
        else if (b inside {[8'hC0:8'hDF]}) n = 3'd1;
        else if (b inside {[8'hE0:8'hEF]}) n = 3'd2;
        else if (b inside {[8'hF0:8'hF7]}) n = 3'd3;
        else if (b inside {[8'hF8:8'hFB]}) n = 3'd4;
        else n = 3'd5;
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] lead_offset(input logic [TRAIL_W-1:0] n);
        logic [WORD_W-1:0] v;
        case (n)
            3'd1: v = 32'h0000_3080;
            3'd2: v = 32'h000E_2080;
            3'd3: v = 32'h03C8_2080;
            3'd4: v = 32'hFA08_2080;
            3'd5: v = 32'h8208_2080;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/u8d_fifo.sv =====
// small register fifo used between the decoder stages
`timescale 1ns / 1ps

module u8d_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/u8d_front.sv =====
// front end: configuration, end flag and classification of each request
`timescale 1ns / 1ps

module u8d_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic                            i_cmd,
    input  logic [u8d_pkg::WORD_W-1:0]      i_unit,
    input  logic                            i_cfg_valid,
    input  logic [u8d_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [u8d_pkg::WORD_W-1:0]      i_cfg_data,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output u8d_pkg::t_op                    o_op
);
    import u8d_pkg::*;

    logic              r_utf8_decode;
    logic [WORD_W-1:0] r_end_code;
    logic              r_end_seen, n_end_seen;
    logic [WORD_W-1:0] r_held_end, n_held_end;
    logic              accept;

    assign accept = i_push && !i_q_full;

    always_comb begin
        n_end_seen = r_end_seen;
        n_held_end = r_held_end;
        o_q_push   = 1'b0;
        o_op.op    = OP_BYTE;
        o_op.trail = trail_count_of(i_unit[7:0]);
        o_op.value = i_unit;
        if (accept) begin
            if (i_cmd) begin
                n_end_seen = 1'b0;
            end else if (r_end_seen) begin
                o_q_push   = 1'b1;
                o_op.op    = OP_END;
                o_op.value = r_held_end;
            end else if (i_unit == r_end_code) begin
                o_q_push   = 1'b1;
                o_op.op    = OP_END;
                n_end_seen = 1'b1;
                n_held_end = i_unit;
            end else if (!r_utf8_decode) begin
                o_q_push   = 1'b1;
                o_op.op    = OP_PASS;
            end else begin
                o_q_push   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utf8_decode <= 1'b1;
            r_end_code    <= '1;
            r_end_seen    <= 1'b0;
            r_held_end    <= '0;
        end else begin
            r_end_seen <= n_end_seen;
            r_held_end <= n_held_end;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_UTF8_DECODE: r_utf8_decode <= i_cfg_data[0];
                    REG_END_CODE:    r_end_code    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== rtl/u8d_back.sv =====
// back end: sequence accumulation and result generation
`timescale 1ns / 1ps

module u8d_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_op_valid,
    input  u8d_pkg::t_op  i_op,
    output logic          o_op_pop,
    input  logic          i_res_full,
    output logic          o_res_push,
    output u8d_pkg::t_res o_res
);
    import u8d_pkg::*;

    logic [WORD_W-1:0]  r_acc, n_acc;
    logic [TRAIL_W-1:0] r_left, n_left;
    logic [TRAIL_W-1:0] r_lead, n_lead;
    logic [WORD_W-1:0]  sum;
    logic [7:0]         b;

    assign o_op_pop = i_op_valid && !i_res_full;
    assign b        = i_op.value[7:0];

    always_comb begin
        n_acc        = r_acc;
        n_left       = r_left;
        n_lead       = r_lead;
        o_res_push   = 1'b0;
        o_res.at_end = 1'b0;
        o_res.value  = i_op.value;
        sum          = '0;
        if (o_op_pop) begin
            case (i_op.op)
                OP_END, OP_PASS: begin
                    o_res_push   = 1'b1;
                    o_res.at_end = (i_op.op == OP_END);
                    n_acc        = '0;
                    n_left       = '0;
                    n_lead       = '0;
                end
                OP_BYTE: begin
                    if (r_left == '0) begin
                        n_lead = i_op.trail;
                        n_left = i_op.trail;
                        sum    = {24'd0, b};
                    end else begin
                        n_left = r_left - 1'b1;
                        sum    = r_acc + {24'd0, b};
                    end
                    if (n_left != '0) begin
                        n_acc = {sum[WORD_W-7:0], 6'd0};
                    end else begin
                        o_res_push  = 1'b1;
                        o_res.value = sum - lead_offset(n_lead);
                        n_acc       = '0;
                        n_lead      = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_left <= '0;
            r_lead <= '0;
        end else begin
            r_acc  <= n_acc;
            r_left <= n_left;
            r_lead <= n_lead;
        end
    end

endmodule

// ===== rtl/utf8_code_unit_decoder.sv =====
// top level of the utf-8 code unit decoder
//
// channel  direction  handshake            payload
// input    in         i_push / o_full      i_cmd, i_unit
// result   out        o_empty / i_pop      o_char_value, o_at_end
// config   in         i_cfg_valid / ready  i_cfg_index, i_cfg_data
//
// one request a cycle sustained; the front classifies in the accept cycle,
// the back decodes one queued request a cycle into the result queue.
// two entry queues part front, back and result side. reset is synchronous
// and clears the end flag, decode state and both queues.
// a stalled result side backs up through the queues to o_full.
`timescale 1ns / 1ps

module utf8_code_unit_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_cmd,
    input  logic [u8d_pkg::WORD_W-1:0]    i_unit,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [u8d_pkg::WORD_W-1:0]    o_char_value,
    output logic                          o_at_end,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [u8d_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [u8d_pkg::WORD_W-1:0]    i_cfg_data
);
    import u8d_pkg::*;

    t_op  front_op, back_op;
    t_res back_res, out_res;
    logic q_push, q_full, q_empty, q_pop;
    logic res_push, res_full;

    assign o_cfg_ready  = 1'b1;
    assign o_full       = q_full;
    assign o_char_value = out_res.value;
    assign o_at_end     = out_res.at_end;

    u8d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_cmd       (i_cmd),
        .i_unit      (i_unit),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_op        (front_op)
    );

    u8d_fifo #(.WIDTH($bits(t_op)), .DEPTH(2)) u_op_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (back_op),
        .o_empty (q_empty)
    );

    u8d_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (!q_empty),
        .i_op       (back_op),
        .o_op_pop   (q_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (back_res)
    );

    u8d_fifo #(.WIDTH($bits(t_res)), .DEPTH(2)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (out_res),
        .o_empty (o_empty)
    );

endmodule
